### hw/rtl/sfcc_pkg.sv
package sfcc_pkg;

  // Data bytes ahead of the check byte in one reply frame (1 or 2)
  localparam int unsigned DataBytes = 2;
  localparam int unsigned PosW      = 2;

  localparam logic [7:0]  CrcPoly    = 8'h31;
  localparam logic [14:0] TempScale  = 15'd17572;
  localparam logic [15:0] TempOffset = 16'd4685;
  localparam logic [14:0] HumScale   = 15'd12500;
  localparam logic [15:0] HumOffset  = 16'd600;

  typedef enum logic {
    KIND_TEMP  = 1'b0,
    KIND_HUMID = 1'b1
  } kind_e;

  // Frame state as seen by the stage that produces results
  typedef struct packed {
    logic        is_check;
    logic [15:0] raw;
    logic [7:0]  crc;
    logic        crc_ok;
    kind_e       kind;
  } frame_t;

  // One byte of CRC-8, MSB first, unrolled
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CrcPoly;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### hw/rtl/sfcc_frame.sv
module sfcc_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  sfcc_pkg::kind_e    kind_i,
  output sfcc_pkg::frame_t   frame_o
);
  import sfcc_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      crc_q, crc_d;
  logic [15:0]     value_q, value_d;
  kind_e           kind_q, kind_d;

  logic        is_check;
  logic        first;
  logic [7:0]  crc_base;
  logic [15:0] value_base;

  assign is_check   = (32'(pos_q) >= DataBytes);
  assign first      = (pos_q == '0);
  assign crc_base   = first ? 8'h00 : crc_q;
  assign value_base = first ? 16'h0000 : value_q;

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    value_d = value_q;
    kind_d  = kind_q;
    if (step_i) begin
      if (is_check) begin
        pos_d = '0;
      end else begin
        if (first) kind_d = kind_i;
        crc_d   = crc8_byte(crc_base, data_byte_i);
        value_d = {value_base[7:0], data_byte_i};
        pos_d   = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= '0;
      value_q <= '0;
      kind_q  <= KIND_TEMP;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      value_q <= value_d;
      kind_q  <= kind_d;
    end
  end

  assign frame_o.is_check = is_check;
  assign frame_o.raw      = value_q;
  assign frame_o.crc      = crc_q;
  assign frame_o.crc_ok   = (crc_q == data_byte_i);
  assign frame_o.kind     = kind_q;

endmodule

### hw/rtl/sfcc_convert.sv
module sfcc_convert (
  input  logic              [15:0] raw_i,
  input  sfcc_pkg::kind_e          kind_i,
  input  logic                     crc_ok_i,
  output logic                     valid_o,
  output logic signed       [14:0] converted_o
);
  import sfcc_pkg::*;

  logic [14:0] scale;
  logic [15:0] offset;
  logic [30:0] prod;
  logic [15:0] diff;

  assign valid_o = crc_ok_i && (raw_i != 16'h0000);

  assign scale  = (kind_i == KIND_HUMID) ? HumScale : TempScale;
  assign offset = (kind_i == KIND_HUMID) ? HumOffset : TempOffset;
  assign prod   = 31'(raw_i) * 31'(scale);
  assign diff   = {1'b0, prod[30:16]} - offset;

  // drop the reading to zero when it fails the CRC check or the raw value is zero
  assign converted_o = valid_o ? signed'(diff[14:0]) : 15'sd0;

endmodule

### hw/rtl/sensor_frame_crc_check_convert_core.sv
// Channel | valid / stall          | payload
// in      | in_valid_i / in_stall_o | data_byte_i, measurement_kind_i
// out     | out_valid_o / out_stall_i | raw_value_o, computed_crc_o, crc_ok_o,
//         |                        | reading_valid_o, converted_value_o, kind_out_o
//
// One byte is taken every cycle into the input register while in_stall_o is low;
// the result of a check byte is loaded into the result register as that byte leaves.
// CRC step, assembly and the one constant multiply sit between those two.
// Data bytes leave the input register whatever the output side does; a check
// byte waits there only while the result register is full and stalled.
// Reset clears the valid flags and the frame state (position, CRC, value, kind).
module sensor_frame_crc_check_convert_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               measurement_kind_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        raw_value_o,
  output logic [7:0]         computed_crc_o,
  output logic               crc_ok_o,
  output logic               reading_valid_o,
  output logic signed [14:0] converted_value_o,
  output logic               kind_out_o
);
  import sfcc_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  kind_e      s1_kind_q;

  logic       out_valid_q;
  logic [15:0] raw_q;
  logic [7:0]  crc_q;
  logic        ok_q;
  logic        rvalid_q;
  logic signed [14:0] conv_q;
  kind_e       kind_q;

  frame_t      frame;
  logic        conv_valid;
  logic signed [14:0] conv;
  logic        out_free;
  logic        s1_go;
  logic        s1_load;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign s1_go     = s1_valid_q && (!frame.is_check || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign s1_load   = in_valid_i && !in_stall_o;

  sfcc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_go),
    .data_byte_i (s1_byte_q),
    .kind_i      (s1_kind_q),
    .frame_o     (frame)
  );

  sfcc_convert u_convert (
    .raw_i       (frame.raw),
    .kind_i      (frame.kind),
    .crc_ok_i    (frame.crc_ok),
    .valid_o     (conv_valid),
    .converted_o (conv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load)     s1_valid_q <= 1'b1;
      else if (s1_go)  s1_valid_q <= 1'b0;
      if (s1_go && frame.is_check) out_valid_q <= 1'b1;
      else if (!out_stall_i)       out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_byte_q <= data_byte_i;
      s1_kind_q <= kind_e'(measurement_kind_i);
    end
    if (s1_go && frame.is_check) begin
      raw_q    <= frame.raw;
      crc_q    <= frame.crc;
      ok_q     <= frame.crc_ok;
      rvalid_q <= conv_valid;
      conv_q   <= conv;
      kind_q   <= frame.kind;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign raw_value_o       = raw_q;
  assign computed_crc_o    = crc_q;
  assign crc_ok_o          = ok_q;
  assign reading_valid_o   = rvalid_q;
  assign converted_value_o = conv_q;
  assign kind_out_o        = kind_q;

`ifndef SYNTH
  a_valid_needs_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reading_valid_o |-> crc_ok_o && (raw_value_o != 16'h0000))
    else $error("reading flagged valid without a good check");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reading_valid_o |-> (converted_value_o == 15'sd0))
    else $error("rejected reading carries a converted value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i && frame.is_check)
    else $error("input stalled without a blocked check byte");
`endif

endmodule
